// ----- hdl/sha256_pkg.sv -----
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  typedef logic [31:0] word_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror32(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ----- hdl/sha256_stream_hasher.sv -----
// byte-serial sha-256 hasher
// input channel: one item per handshake; tdata = data_byte, tuser = {end_of_message, has_byte}.
// an item whose byte does not complete a 64-byte block and does not end the message
// is taken while the input stays ready. a byte that fills a block starts the compression:
// the message schedule is loaded from the block memory (one word from 4 byte reads),
// then 64 rounds run through one shared round unit and the result is added into the
// hash, after which the input is ready again. an end item writes the padding one byte a
// cycle (from the fill position to the block's end, and a whole second block if needed),
// runs one or two compressions, then shows the eight digest words on the output channel
// one at a time, index 0 first, last_word on index 7, then a state restoring the initial hash.
// the input is not ready while a block is compressed or the digest is shown.
// if the receiver stalls, the current word holds on out_tdata until taken; nothing is lost.
// reset (rst_n low, synchronous) loads the initial hash values and clears the fill and
// bit counts; the block memory is not cleared, it is always written before it is read.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // has_byte, end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [3:0]  out_tuser   // word_index[2:0], last_word
);

  logic [7:0]  mem_r [BlockBytes];
  logic [7:0]  rd_byte_r;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic        final_r;   // compressing final padded block
  logic        second_r;  // a second padding block still follows
  logic [63:0] total_r;
  logic [6:0]  cnt_r;     // round / load / pad counter
  logic [1:0]  bsel_r;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];
  word_t       acc_r;
  logic [2:0]  oidx_r;

  logic        acc_in;
  logic        in_has, in_end;
  logic [5:0]  rd_addr;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;

  assign in_has = in_tuser[0];
  assign in_end = in_tuser[1];
  assign in_tready = (state_r == ST_IDLE);
  assign acc_in = in_tvalid && in_tready;

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = h_r[oidx_r];
  assign out_tuser  = {oidx_r == 3'd7, oidx_r};

  // padding byte for position cnt in pad state
  logic [7:0] pad_byte;
  logic [5:0] pad_pos;
  logic [2:0] len_sel;
  assign pad_pos = cnt_r[5:0];
  assign len_sel = 3'd7 - pad_pos[2:0];
  always_comb begin
    if (pad_pos >= 6'd56 && !second_r) pad_byte = total_r[{len_sel, 3'b000} +: 8];
    else                               pad_byte = 8'h00;
  end

  // load reads byte address from cnt (word) and bsel
  assign rd_addr = {cnt_r[3:0], bsel_r};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill_r;
    wr_data = in_tdata;
    if (acc_in && in_has) begin
      wr_en = 1'b1;
    end else if (state_r == ST_PAD) begin
      wr_en = 1'b1;
      wr_addr = pad_pos;
      wr_data = (pad_pos == fill_r && cnt_r[6]) ? PadByte : pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_byte_r <= mem_r[rd_addr];
  end

  // shared round unit
  word_t s0, s1, wnew, bs1, ch, bs0, maj, x1, x2;
  always_comb begin
    s0 = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    bs1 = ror32(v_r[4], 6) ^ ror32(v_r[4], 11) ^ ror32(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    bs0 = ror32(v_r[0], 2) ^ ror32(v_r[0], 13) ^ ror32(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    x1  = v_r[7] + bs1 + ch + RoundK[cnt_r[5:0]] + w_r[0];
    x2  = bs0 + maj;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_has && fill_r == 6'd63) state_nxt = ST_LOAD;
          else if (in_end)               state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pad_pos == 6'd63) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (cnt_r == 7'd16 && bsel_r == 2'd0) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_r[5:0] == 6'(Rounds - 1)) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (second_r)     state_nxt = ST_PAD;
        else if (final_r) state_nxt = ST_EMIT;
        else              state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_tready && oidx_r == 3'd7) state_nxt = ST_DONE;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      bits_r   <= '0;
      final_r  <= 1'b0;
      second_r <= 1'b0;
      cnt_r    <= '0;
      bsel_r   <= '0;
      oidx_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r  <= '0;
          bsel_r <= '0;
          if (acc_in) begin
            logic [5:0] f;
            f = fill_r + 6'(in_has);
            if (in_has) fill_r <= f;
            if (in_has && fill_r == 6'd63) begin
              bits_r   <= bits_r + 64'd512;
              second_r <= in_end;
              if (in_end) total_r <= bits_r + 64'd512;
            end else if (in_end) begin
              total_r  <= bits_r + {55'd0, f, 3'b000};
              second_r <= (f > 6'd55);
              final_r  <= (f <= 6'd55);
              cnt_r    <= {1'b1, f};
            end
          end
        end
        ST_PAD: begin
          // cnt[6] marks the first padded position (the 0x80 byte)
          if (pad_pos == 6'd63) cnt_r <= '0;
          else                  cnt_r <= {1'b0, pad_pos + 6'd1};
        end
        ST_LOAD: begin
          // byte read is registered: shift in at bsel>0 or cnt advance
          if (!(cnt_r == 7'd0 && bsel_r == 2'd0)) begin
            acc_r <= {acc_r[23:0], rd_byte_r};
            if (bsel_r == 2'd0) begin
              for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
              w_r[15] <= {acc_r[23:0], rd_byte_r};
            end
          end
          bsel_r <= bsel_r + 2'd1;
          if (bsel_r == 2'd3) cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd16 && bsel_r == 2'd0) begin
            cnt_r <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        ST_ROUND: begin
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + x1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= x1 + x2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= wnew;
          cnt_r <= cnt_r + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          // padding block after a full data block starts with the 0x80 byte
          cnt_r  <= second_r ? {fill_r == 6'd0, 6'd0} : 7'd0;
          bsel_r <= '0;
          if (second_r) begin
            second_r <= 1'b0;
            final_r  <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_tready) oidx_r <= oidx_r + 3'd1;
        end
        ST_DONE: begin
          for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
          fill_r  <= '0;
          bits_r  <= '0;
          final_r <= 1'b0;
          oidx_r  <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
